@@ src/dfp_pkg.sv @@
// Shared types and constants for the decimal fixed-point parser.
// Holds the byte class codes, the queue entry layout and the parse limits.
// No dependencies.
package dfp_pkg;

   // ASCII codes the classifier looks for
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // buffer length limit; position is an 8-bit count
   localparam int unsigned MAX_BUFFER_LENGTH = 255;
   localparam int unsigned POS_HW_MAX        = 255;
   localparam int unsigned POS_LIMIT =
      (MAX_BUFFER_LENGTH > POS_HW_MAX) ? POS_HW_MAX : MAX_BUFFER_LENGTH;

   // largest magnitude a digit may produce
   localparam logic [34:0] MAG_LIMIT = 35'h0_7FFF_FFFF;

   // default depth of the front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 4;

   // byte classes produced by the front end
   typedef enum logic [2:0] {
      KIND_DIGIT = 3'd0,
      KIND_PLUS  = 3'd1,
      KIND_MINUS = 3'd2,
      KIND_DOT   = 3'd3,
      KIND_OTHER = 3'd4
   } kind_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  digit;
      logic        first;
      logic        last;
   } entry_type;

endpackage

@@ src/dfp_front.sv @@
// Front end of the parser: takes request bytes and classifies them.
// Depends on dfp_pkg for the class codes and the queue entry type.
module dfp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_first_byte,
   input  logic               req_last_byte,
   input  logic               queue_full,
   output logic               push,
   output dfp_pkg::entry_type push_entry
);
   import dfp_pkg::*;

   // hold requests off while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify the byte
   always_comb begin
      push_entry.first = req_first_byte;
      push_entry.last  = req_last_byte;
      push_entry.digit = 4'(req_char_byte - CHAR_ZERO);
      if (req_char_byte >= CHAR_ZERO && req_char_byte <= CHAR_NINE) begin
         push_entry.kind = KIND_DIGIT;
      end else if (req_char_byte == CHAR_PLUS) begin
         push_entry.kind = KIND_PLUS;
      end else if (req_char_byte == CHAR_MINUS) begin
         push_entry.kind = KIND_MINUS;
      end else if (req_char_byte == CHAR_DOT) begin
         push_entry.kind = KIND_DOT;
      end else begin
         push_entry.kind = KIND_OTHER;
      end
   end

   // no push may happen while the queue reports full
   assert property (@(posedge clock) disable iff (reset) queue_full |-> !push)
      else $error("push while queue full");
   assert property (@(posedge clock) disable iff (reset)
      push && push_entry.kind == KIND_DIGIT |-> push_entry.digit <= 4'd9)
      else $error("digit out of range");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> push)
      else $error("accepted request not queued");

endmodule

@@ src/dfp_queue.sv @@
// Short queue between the front end and the back end of the parser.
// Depends on dfp_pkg for the entry type.
module dfp_queue #(
   parameter int unsigned DEPTH = dfp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dfp_pkg::entry_type push_entry,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output dfp_pkg::entry_type pop_entry
);
   import dfp_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type         store_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count past depth");
   assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

endmodule

@@ src/dfp_back.sv @@
// Back end of the parser: runs the parse state on classified bytes and
// holds the result register. Depends on dfp_pkg for types and limits.
module dfp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   output logic               pop,
   input  dfp_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_parsed_value,
   output logic [7:0]         rsp_decimal_count,
   output logic [7:0]         rsp_consumed_count
);
   import dfp_pkg::*;

   logic [30:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        dot_ff, dot_in;
   logic        stop_ff, stop_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  frac_ff, frac_in;

   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  dcount_ff, dcount_in;
   logic [7:0]  ccount_ff, ccount_in;

   // starting point for this byte: cleared when a new buffer opens
   logic [30:0] b_mag;
   logic        b_neg, b_dot, b_stop;
   logic [7:0]  b_pos, b_frac;
   logic        at_start;
   logic [34:0] next_mag;

   // parse state after this byte, before the last byte clears it
   logic [30:0] res_mag;
   logic        res_neg;
   logic [7:0]  res_pos, res_frac;

   // take an entry whenever the result register can take a result
   assign pop = !queue_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      b_mag  = pop_entry.first ? '0   : mag_ff;
      b_neg  = pop_entry.first ? 1'b0 : neg_ff;
      b_dot  = pop_entry.first ? 1'b0 : dot_ff;
      b_stop = pop_entry.first ? 1'b0 : stop_ff;
      b_pos  = pop_entry.first ? '0   : pos_ff;
      b_frac = pop_entry.first ? '0   : frac_ff;
      at_start = (b_pos == '0) && !b_stop;
      // times ten as two shifts, plus the digit
      next_mag = ({4'd0, b_mag} << 3) + ({4'd0, b_mag} << 1) + 35'(pop_entry.digit);
   end

   // parse step
   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      dot_in   = dot_ff;
      stop_in  = stop_ff;
      pos_in   = pos_ff;
      frac_in  = frac_ff;
      res_mag  = mag_ff;
      res_neg  = neg_ff;
      res_pos  = pos_ff;
      res_frac = frac_ff;
      if (pop) begin
         mag_in  = b_mag;
         neg_in  = b_neg;
         dot_in  = b_dot;
         stop_in = b_stop;
         pos_in  = b_pos;
         frac_in = b_frac;
         if (!b_stop) begin
            if (b_pos >= 8'(POS_LIMIT)) begin
               stop_in = 1'b1;
            end else begin
               case (pop_entry.kind)
                  KIND_PLUS, KIND_MINUS: begin
                     if (at_start) begin
                        neg_in = (pop_entry.kind == KIND_MINUS);
                        pos_in = b_pos + 8'd1;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
                  KIND_DIGIT: begin
                     if (next_mag > MAG_LIMIT) begin
                        stop_in = 1'b1;
                     end else begin
                        mag_in = next_mag[30:0];
                        pos_in = b_pos + 8'd1;
                        if (b_dot) begin
                           frac_in = b_frac + 8'd1;
                        end
                     end
                  end
                  KIND_DOT: begin
                     if (!b_dot) begin
                        dot_in = 1'b1;
                        pos_in = b_pos + 8'd1;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
                  default: begin
                     stop_in = 1'b1;
                  end
               endcase
            end
         end
         res_mag  = mag_in;
         res_neg  = neg_in;
         res_pos  = pos_in;
         res_frac = frac_in;
         // the last byte closes the buffer
         if (pop_entry.last) begin
            mag_in  = '0;
            neg_in  = 1'b0;
            dot_in  = 1'b0;
            stop_in = 1'b0;
            pos_in  = '0;
            frac_in = '0;
         end
      end
   end

   // result register
   always_comb begin
      valid_in  = rsp_stall ? valid_ff : 1'b0;
      value_in  = value_ff;
      dcount_in = dcount_ff;
      ccount_in = ccount_ff;
      if (pop && pop_entry.last) begin
         valid_in  = 1'b1;
         value_in  = res_neg ? (32'd0 - {1'b0, res_mag}) : {1'b0, res_mag};
         dcount_in = res_frac;
         ccount_in = res_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         dot_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         pos_ff   <= '0;
         frac_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         dot_ff   <= dot_in;
         stop_ff  <= stop_in;
         pos_ff   <= pos_in;
         frac_ff  <= frac_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      dcount_ff <= dcount_in;
      ccount_ff <= ccount_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_parsed_value   = signed'(value_ff);
   assign rsp_decimal_count  = dcount_ff;
   assign rsp_consumed_count = ccount_ff;

   assert property (@(posedge clock) disable iff (reset) frac_ff <= pos_ff)
      else $error("fraction digits exceed consumed bytes");
   assert property (@(posedge clock) disable iff (reset) pos_ff <= 8'(POS_LIMIT))
      else $error("position past buffer limit");
   assert property (@(posedge clock) disable iff (reset) !dot_ff |-> frac_ff == '0)
      else $error("fraction digits without a dot");

endmodule

@@ src/decimal_fixed_point_parser_top.sv @@
// Top level of the decimal fixed-point parser.
// Instantiates dfp_front, dfp_queue and dfp_back; depends on dfp_pkg.

// Takes one request byte per cycle while the queue has room and parses an
// optional leading sign, decimal digits and at most one dot; a byte marked
// last produces one response with the signed value, the digits after the
// dot and the bytes consumed. Throughput is one byte per cycle unless
// rsp_stall holds the response register: the back end does one shift-add
// times ten and compare per byte. A taken byte goes into the front-to-back
// queue; the back end pops it, runs the parse step and, for a last byte,
// loads the response register. req_stall rises only when the queue is full,
// which happens when the response register is held by rsp_stall.
module decimal_fixed_point_parser_top #(
   parameter int unsigned QUEUE_DEPTH = dfp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_first_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_parsed_value,
   output logic [7:0]         rsp_decimal_count,
   output logic [7:0]         rsp_consumed_count
);
   import dfp_pkg::*;

   logic      push, pop, q_full, q_empty;
   entry_type push_entry, pop_entry;

   dfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_byte  (req_char_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .queue_full     (q_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   dfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .empty      (q_empty),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   dfp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (q_empty),
      .pop                (pop),
      .pop_entry          (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_parsed_value   (rsp_parsed_value),
      .rsp_decimal_count  (rsp_decimal_count),
      .rsp_consumed_count (rsp_consumed_count)
   );

endmodule

@@ tb/decimal_fixed_point_parser_top_tb.sv @@
// Testbench for decimal_fixed_point_parser_top: drives byte requests with random idling
// and stalls, predicts each parsed number and checks every response against it.
// Depends on dfp_pkg and the parser RTL.
module decimal_fixed_point_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfp_pkg::*;

   localparam int unsigned MAX_CYCLES    = 500000;
   localparam int unsigned ITEMS_PER_RUN = 700;
   localparam int unsigned MAX_REPORTS   = 10;

   // one parsed number as the response channel carries it
   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         decimals;
      logic [7:0]         consumed;
   } parsed_number_type;

   // tracks the parse state of the current buffer and the numbers still due
   class parse_scoreboard;
      logic [30:0]       magnitude;
      bit                negative;
      bit                dot_seen;
      bit                stopped;
      logic [7:0]        position;
      logic [7:0]        fraction_digits;
      parsed_number_type numbers_due[$];
      int unsigned       mismatches;

      function new();
         clear_parse();
         mismatches = 0;
      endfunction

      function void clear_parse();
         magnitude       = '0;
         negative        = 1'b0;
         dot_seen        = 1'b0;
         stopped         = 1'b0;
         position        = '0;
         fraction_digits = '0;
      endfunction

      function int unsigned pending();
         return numbers_due.size();
      endfunction

      // advance the parse by one accepted request byte
      function void note_request(logic [7:0] ch, bit first, bit last);
         logic [34:0]       scaled;
         logic [31:0]       word;
         parsed_number_type number;
         if (first)
            clear_parse();
         if (!stopped) begin
            if (position >= POS_LIMIT) begin
               stopped = 1'b1;
            end else if (position == 0 && (ch == CHAR_MINUS || ch == CHAR_PLUS)) begin
               negative = (ch == CHAR_MINUS);
               position = position + 8'd1;
            end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
               scaled = 35'(magnitude) * 35'd10 + 35'(ch - CHAR_ZERO);
               if (scaled > MAG_LIMIT) begin
                  stopped = 1'b1;
               end else begin
                  magnitude = scaled[30:0];
                  position  = position + 8'd1;
                  if (dot_seen)
                     fraction_digits = fraction_digits + 8'd1;
               end
            end else if (ch == CHAR_DOT && !dot_seen) begin
               dot_seen = 1'b1;
               position = position + 8'd1;
            end else begin
               stopped = 1'b1;
            end
         end
         if (last) begin
            word = {1'b0, magnitude};
            if (negative)
               word = -word;
            number.value    = $signed(word);
            number.decimals = fraction_digits;
            number.consumed = position;
            numbers_due.push_back(number);
            clear_parse();
         end
      endfunction

      // compare one accepted response with the oldest number due
      function void check_response(logic signed [31:0] value, logic [7:0] decimals,
                                   logic [7:0] consumed);
         parsed_number_type want;
         if (numbers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response with nothing due: value %0d decimals %0d consumed %0d",
                        value, decimals, consumed);
            return;
         end
         want = numbers_due.pop_front();
         if (value !== want.value || decimals !== want.decimals ||
             consumed !== want.consumed) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: value %0d/%0d decimals %0d/%0d consumed %0d/%0d (exp/got)",
                        want.value, value, want.decimals, decimals,
                        want.consumed, consumed);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_byte = 8'h00;
   logic               req_first_byte = 1'b0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_parsed_value;
   logic [7:0]         rsp_decimal_count;
   logic [7:0]         rsp_consumed_count;

   parse_scoreboard    sb;
   logic [7:0]         text[$];
   int unsigned        send_idle_pct = 0;
   int unsigned        stall_pct = 0;
   int unsigned        long_left = 2;
   int unsigned        cycle_count = 0;

   decimal_fixed_point_parser_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_parsed_value   (rsp_parsed_value),
      .rsp_decimal_count  (rsp_decimal_count),
      .rsp_consumed_count (rsp_consumed_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side: check on accept, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_parsed_value, rsp_decimal_count, rsp_consumed_count);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one request byte: optional idle cycles, then hold until accepted
   task automatic send_request(input logic [7:0] ch, input bit first, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_byte  <= ch;
      req_first_byte <= first;
      req_last_byte  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(ch, first, last);
   endtask

   // send the bytes in text as one buffer
   task automatic send_text(input bit mark_first, input bit mark_last);
      int unsigned n;
      n = text.size();
      for (int i = 0; i < n; i++)
         send_request(text[i], mark_first && i == 0, mark_last && i == n - 1);
   endtask

   task automatic send_str(input string s, input bit mark_first, input bit mark_last);
      text.delete();
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      send_text(mark_first, mark_last);
   endtask

   task automatic push_sign();
      case ($urandom_range(2))
         1: text.push_back(CHAR_PLUS);
         2: text.push_back(CHAR_MINUS);
         default: ;
      endcase
   endtask

   // build and send one random buffer; returns how many bytes count toward the run
   task automatic send_random_buffer(output int unsigned counted);
      int unsigned pick;
      int unsigned n;
      int unsigned dot_at;
      int unsigned flags;
      bit          mark_first;
      bit          mark_last;
      bit          long_buffer;
      string       near_limit;
      text.delete();
      mark_first  = 1'b1;
      mark_last   = 1'b1;
      long_buffer = 1'b0;
      pick        = $urandom_range(99);
      near_limit  = "214748364";
      if (pick >= 97 && long_left > 0) begin
         // runs up to or past the length limit; zeros keep the magnitude in range
         long_left--;
         long_buffer = 1'b1;
         if ($urandom_range(1))
            text.push_back(CHAR_DOT);
         n = $urandom_range(250, 270);
         for (int i = 0; i < n; i++)
            text.push_back(CHAR_ZERO);
      end else if (pick >= 65 && pick < 77) begin
         // around the overflow boundary, sometimes with leading zeros or more digits
         push_sign();
         if ($urandom_range(3) == 0)
            text.push_back(CHAR_ZERO);
         for (int i = 0; i < near_limit.len(); i++)
            text.push_back(near_limit[i]);
         text.push_back(CHAR_ZERO + 8'($urandom_range(5, 9)));
         if ($urandom_range(1))
            text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end else if (pick >= 77 && pick < 90) begin
         // noise: raw bytes mixed with parser characters
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: text.push_back(CHAR_DOT);
               1: text.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
               2: text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
               default: text.push_back(8'($urandom_range(255)));
            endcase
         end
      end else begin
         // well-formed number with an optional dot and a rare trailing byte
         push_sign();
         n      = $urandom_range(12);
         dot_at = $urandom_range(n + 3);
         for (int i = 0; i <= n; i++) begin
            if (i == dot_at)
               text.push_back(CHAR_DOT);
            if (i < n)
               text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         if ($urandom_range(7) == 0)
            text.push_back(8'($urandom_range(255)));
      end
      if (text.size() == 0)
         text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      // broken framing now and then: no start mark or no end mark
      if (!long_buffer) begin
         flags = $urandom_range(19);
         if (flags == 0)
            mark_first = 1'b0;
         else if (flags == 1)
            mark_last = 1'b0;
      end
      send_text(mark_first, mark_last);
      counted = text.size();
   endtask

   initial begin
      int unsigned counted;
      int unsigned total;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: signs, zero, dots, junk, byte extremes, framing cases
      send_str("-", 1, 1);
      send_str("+9", 1, 1);
      send_str("-0", 1, 1);
      send_str("1.5", 1, 1);
      send_str("..1", 1, 1);
      send_str("a", 1, 1);
      text.delete();
      text.push_back(8'h00);
      send_text(1, 1);
      text.delete();
      text.push_back(8'hFF);
      send_text(1, 1);
      send_str("+-", 1, 1);
      send_str("4", 1, 0);
      send_str("3", 1, 1);
      send_str("8", 0, 1);

      // random part in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         total = 0;
         while (total < ITEMS_PER_RUN / 4) begin
            send_random_buffer(counted);
            total += counted;
         end
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      // drain, then keep running to catch stray responses
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
